>>> sv/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the adjtime slewing clock
// Transaction structs, the classified command passed from front to back,
// mode and command codes, and the queue depth, slew limit and reset shift.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int unsigned CSA_QUEUE_DEPTH = 2;

  localparam logic [4:0]  CSA_SHIFT_RESET = 5'd6;
  localparam logic [63:0] CSA_SLEW_LIMIT  = 64'd2146000000;

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_SLEW = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_SET,
    OP_SLEW,
    OP_REJECT
  } csa_op_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        since_boot_us;
    logic [63:0]        set_time_us;
    logic signed [63:0] slew_req_us;
  } csa_in_t;

  typedef struct packed {
    logic [63:0]        realtime_us;
    logic signed [31:0] corr_left_us;
    logic signed [31:0] corr_prior_us;
    logic               error;
  } csa_out_t;

  // Classified command: everything that does not depend on clock state
  typedef struct packed {
    csa_op_e            op;
    logic [63:0]        sb;        // since-boot count
    logic [63:0]        sb_sh;     // since-boot count shifted by slew_shift
    logic [63:0]        new_boot;  // set time minus since-boot, for a set
    logic signed [31:0] new_rem;   // requested correction, for a slew
  } csa_cmd_t;

  // Result of the state update, before the final realtime sum
  typedef struct packed {
    logic [63:0]        boot;
    logic [63:0]        sb;
    logic signed [31:0] rem;
    logic signed [31:0] prev;
    logic               error;
  } csa_mid_t;

endpackage

>>> sv/clock_slew_adjtime.sv
// ----------------------------------------------------------------------------
// clock_slew_adjtime: real-time clock with gradual adjtime-style slewing
// Keeps a boot offset and an optional slew (start stamp and signed
// remaining correction); each transaction reads, sets or starts a slew.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | csa_in_t  (mode, times, offset)
//  out     | output    | out_valid_o/out_stall_i | csa_out_t (realtime, remaining)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | slew_shift, 5 bits
//
// One transaction per cycle sustained while out_stall_i is low; an accepted
// transaction is written to the queue, then popped into the state update
// and the mid register, then summed into the output register (realtime).
// The state update loop (shifted difference, compare, offset add) is
// combinational between the state registers, which sets the rate.
// Reset clears the clock state, sets slew_shift to 6 and empties all stages.
// A stalled output holds the result stages; the two-entry queue then fills
// and raises in_stall_o, which depends on the queue count alone.
// Configuration writes are taken every cycle (cfg_ready_o is tied high).
// ----------------------------------------------------------------------------
module clock_slew_adjtime (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csa_pkg::csa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csa_pkg::csa_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [4:0]        cfg_slew_shift_i
);
  import csa_pkg::*;

  logic     push, queue_full, cmd_valid, cmd_pop, cfg_we;
  logic [4:0] shift;
  csa_cmd_t cmd_in, cmd_head;

  // Configuration never waits
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Classify the incoming transaction and precompute its operands
  csa_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .shift_i      (shift),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  // Decouple acceptance from the state update
  csa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (queue_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  // Apply slew and command, then drive the result
  csa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_slew_shift_i (cfg_slew_shift_i),
    .shift_o          (shift),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd_head),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_o       (out_data_o)
  );

endmodule

>>> sv/csa_front.sv
// ----------------------------------------------------------------------------
// csa_front: input classification
// Decode the mode, range-check the slew offset and precompute the
// state-independent operands of each transaction before it is queued.
// ----------------------------------------------------------------------------
module csa_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csa_pkg::csa_in_t  in_data_i,
  input  logic [4:0]        shift_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output csa_pkg::csa_cmd_t cmd_o
);
  import csa_pkg::*;

  logic        neg;
  logic [63:0] mag;
  logic        too_large;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  assign neg       = in_data_i.slew_req_us[63];
  assign mag       = neg ? (64'd0 - in_data_i.slew_req_us) : in_data_i.slew_req_us;
  assign too_large = mag > CSA_SLEW_LIMIT;

  always_comb begin
    cmd_o.sb       = in_data_i.since_boot_us;
    cmd_o.sb_sh    = in_data_i.since_boot_us >> shift_i;
    cmd_o.new_boot = in_data_i.set_time_us - in_data_i.since_boot_us;
    cmd_o.new_rem  = in_data_i.slew_req_us[31:0];
    unique case (in_data_i.mode)
      MODE_SET:  cmd_o.op = OP_SET;
      MODE_SLEW: cmd_o.op = too_large ? OP_REJECT : OP_SLEW;
      default:   cmd_o.op = OP_READ;
    endcase
  end

endmodule

>>> sv/csa_fifo.sv
// ----------------------------------------------------------------------------
// csa_fifo: command queue
// Short queue between classification and state update so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module csa_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csa_pkg::csa_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output csa_pkg::csa_cmd_t cmd_o
);
  import csa_pkg::*;

  localparam int unsigned PtrW = (CSA_QUEUE_DEPTH > 1) ? $clog2(CSA_QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CSA_QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CSA_QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CSA_QUEUE_DEPTH);

  csa_cmd_t        mem_q [CSA_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/csa_back.sv
// ----------------------------------------------------------------------------
// csa_back: clock state and slew engine
// Hold boot offset, slew start and remaining correction; when a queued
// command is popped, apply the slew (reads and slews) and the command,
// then form the realtime sum from the mid register into the output register.
// ----------------------------------------------------------------------------
module csa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_slew_shift_i,
  output logic [4:0]        shift_o,
  input  logic              cmd_valid_i,
  input  csa_pkg::csa_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csa_pkg::csa_out_t out_data_o
);
  import csa_pkg::*;

  logic [4:0]         shift_q;
  logic [63:0]        boot_q, boot_d;
  logic [63:0]        start_q, start_d;
  logic [63:0]        start_sh_q, start_sh_d;
  logic signed [31:0] rem_q, rem_d;

  logic     mid_v_q, out_v_q;
  csa_mid_t mid_q, mid_d;
  csa_out_t out_q;
  logic     out_free, mid_free;

  // Slew step terms
  logic               cancel, active, stepping, done, rem_neg;
  logic [63:0]        corr, delta, boot_step;
  logic [31:0]        rem_mag;
  logic signed [31:0] rem_step;
  logic [63:0]        boot_a, start_a, start_sh_a;
  logic signed [31:0] rem_a;

  assign shift_o     = shift_q;
  assign out_free    = !out_v_q || !out_stall_i;
  assign mid_free    = !mid_v_q || out_free;
  assign cmd_pop_o   = cmd_valid_i && mid_free;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign cancel   = (boot_q == '0) || (cmd_i.sb < start_q);
  assign active   = (start_q != '0) && !cancel;
  assign corr     = cmd_i.sb_sh - start_sh_q;
  assign stepping = active && (corr != '0);
  assign rem_neg  = rem_q[31];
  assign rem_mag  = rem_neg ? (32'd0 - rem_q) : rem_q;
  assign done     = (corr[63:32] != '0) || (corr[31:0] >= rem_mag);
  assign delta    = done ? {32'd0, rem_mag} : corr;
  assign boot_step = rem_neg ? (boot_q - delta) : (boot_q + delta);
  assign rem_step  = rem_neg ? (rem_q + corr[31:0]) : (rem_q - corr[31:0]);

  always_comb begin
    boot_a     = boot_q;
    start_a    = cancel ? '0 : start_q;
    start_sh_a = cancel ? '0 : start_sh_q;
    rem_a      = rem_q;
    if (stepping) begin
      boot_a = boot_step;
      if (done) begin
        start_a    = '0;
        start_sh_a = '0;
      end else begin
        start_a    = cmd_i.sb;
        start_sh_a = cmd_i.sb_sh;
        rem_a      = rem_step;
      end
    end
  end

  always_comb begin
    boot_d      = boot_q;
    start_d     = start_q;
    start_sh_d  = start_sh_q;
    rem_d       = rem_q;
    mid_d.sb    = cmd_i.sb;
    mid_d.prev  = '0;
    mid_d.error = 1'b0;
    if (cmd_pop_o) begin
      unique case (cmd_i.op)
        OP_READ: begin
          boot_d     = boot_a;
          start_d    = start_a;
          start_sh_d = start_sh_a;
          rem_d      = rem_a;
        end
        OP_SET: begin
          boot_d     = cmd_i.new_boot;
          start_d    = '0;
          start_sh_d = '0;
        end
        OP_SLEW: begin
          boot_d     = boot_a;
          start_d    = cmd_i.sb;
          start_sh_d = cmd_i.sb_sh;
          rem_d      = cmd_i.new_rem;
          mid_d.prev = (start_q != '0) ? rem_q : '0;
        end
        OP_REJECT: begin
          mid_d.error = 1'b1;
        end
        default: begin
          mid_d.error = 1'b0;
        end
      endcase
    end
    // Keep the shifted start in step with a new shift value
    if (cfg_we_i) begin
      start_sh_d = start_q >> cfg_slew_shift_i;
    end
    mid_d.boot = boot_d;
    mid_d.rem  = (start_d != '0) ? rem_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q    <= CSA_SHIFT_RESET;
      boot_q     <= '0;
      start_q    <= '0;
      start_sh_q <= '0;
      rem_q      <= '0;
      mid_v_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shift_q <= cfg_slew_shift_i;
      end
      boot_q     <= boot_d;
      start_q    <= start_d;
      start_sh_q <= start_sh_d;
      rem_q      <= rem_d;
      if (mid_free) begin
        mid_v_q <= cmd_pop_o;
      end
      if (out_free) begin
        out_v_q <= mid_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      mid_q <= mid_d;
    end
    if (out_free && mid_v_q) begin
      out_q.realtime_us   <= mid_q.boot + mid_q.sb;
      out_q.corr_left_us  <= mid_q.rem;
      out_q.corr_prior_us <= mid_q.prev;
      out_q.error         <= mid_q.error;
    end
  end

endmodule

>>> sv/csa_checker.sv
// ----------------------------------------------------------------------------
// csa_checker: port-level checks for the slewing clock
// Watch the output channel and result fields over time.
// ----------------------------------------------------------------------------
module csa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input csa_pkg::csa_out_t out_data_o,
  input logic              cfg_ready_o
);
  import csa_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // A rejected slew reports no previous correction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.corr_prior_us == 32'sd0)
    else $error("rejected slew with nonzero previous correction");

  // Outstanding correction stays within the slew limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.corr_left_us <= 32'sd2146000000) &&
                    (out_data_o.corr_left_us >= -32'sd2146000000))
    else $error("remaining correction out of range");

  // Configuration is always accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind clock_slew_adjtime csa_checker u_csa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
